[src/tsrb_pkg.sv]
// ----------------------------------------------------------------------------
// tsrb_pkg: shared types and constants for the sync retry backoff timer
// Holds the opcodes, register indexes, config, item and result records,
// and the wraparound time compare used by the step logic.
// ----------------------------------------------------------------------------
package tsrb_pkg;

    // Opcodes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Config register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_RESYNC_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID_SEC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_CAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT   = 3'd4;

    // Config reset values
    localparam logic [30:0] RESYNC_PERIOD_RST = 31'd21600000;
    localparam logic [31:0] MIN_VALID_SEC_RST = 32'd1700000000;
    localparam logic [15:0] BACKOFF_BASE_RST  = 16'd1000;
    localparam logic [31:0] BACKOFF_CAP_RST   = 32'd60000;
    localparam logic [31:0] STALE_LIMIT_RST   = 32'd3600000;

    // Retry policy
    localparam logic [3:0] MAX_ATTEMPTS  = 4'd10;
    localparam int         SHIFT_LIMIT   = 5;
    localparam int         RESTART_EVERY = 5;
    localparam int         SHIFT_W       = 3;
    localparam int         DELAY_W       = 16 + SHIFT_LIMIT;

    typedef struct packed {
        logic [30:0] resync_period_ms;
        logic [31:0] min_valid_seconds;
        logic [15:0] backoff_base_ms;
        logic [31:0] backoff_cap_ms;
        logic [31:0] stale_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic [31:0] wall_seconds;
    } t_item;

    typedef struct packed {
        logic        restart_client;
        logic        sync_ok;
        logic        first_sync;
        logic        sync_failed;
        logic        time_valid;
        logic        stale;
        logic [3:0]  attempt_count;
        logic [31:0] retry_at_ms;
    } t_result;

    // True when a is at or after b in wraparound time
    function automatic logic reached(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return ~diff[31];
    endfunction

    // True when a failure at this count restarts the client (zero or multiple of five)
    function automatic logic restart_due(input logic [3:0] cnt);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k * RESTART_EVERY < 16; k++) begin
            if (cnt == 4'(k * RESTART_EVERY)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

[src/tsrb_cfg.sv]
// ----------------------------------------------------------------------------
// tsrb_cfg: configuration register file
// Takes one register write per transfer; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tsrb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tsrb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output tsrb_pkg::t_cfg                o_cfg
);

    tsrb_pkg::t_cfg r_cfg;

    // Always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Hold register values, update on a write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.resync_period_ms  <= tsrb_pkg::RESYNC_PERIOD_RST;
            r_cfg.min_valid_seconds <= tsrb_pkg::MIN_VALID_SEC_RST;
            r_cfg.backoff_base_ms   <= tsrb_pkg::BACKOFF_BASE_RST;
            r_cfg.backoff_cap_ms    <= tsrb_pkg::BACKOFF_CAP_RST;
            r_cfg.stale_limit_ms    <= tsrb_pkg::STALE_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tsrb_pkg::REG_RESYNC_PERIOD: r_cfg.resync_period_ms  <= i_cfg_data[30:0];
                tsrb_pkg::REG_MIN_VALID_SEC: r_cfg.min_valid_seconds <= i_cfg_data;
                tsrb_pkg::REG_BACKOFF_BASE:  r_cfg.backoff_base_ms   <= i_cfg_data[15:0];
                tsrb_pkg::REG_BACKOFF_CAP:   r_cfg.backoff_cap_ms    <= i_cfg_data;
                tsrb_pkg::REG_STALE_LIMIT:   r_cfg.stale_limit_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[src/tsrb_core.sv]
// ----------------------------------------------------------------------------
// tsrb_core: sync scheduling state and per-item step logic
// Computes the result of one item from the state registers and updates the
// state when the item is taken.
// ----------------------------------------------------------------------------
module tsrb_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsrb_pkg::t_cfg    i_cfg,
    input  logic              i_en,
    input  tsrb_pkg::t_item   i_item,
    output tsrb_pkg::t_result o_res
);

    logic        r_valid_flag;
    logic        r_request_pending;
    logic [31:0] r_next_try_ms;
    logic [31:0] r_next_resync_ms;
    logic [3:0]  r_fail_count;
    logic [31:0] r_last_sync_ms;

    logic        n_valid_flag;
    logic        n_request_pending;
    logic [31:0] n_next_try_ms;
    logic [31:0] n_next_resync_ms;
    logic [3:0]  n_fail_count;
    logic [31:0] n_last_sync_ms;

    logic [31:0]                       w_resync_at;
    logic [tsrb_pkg::SHIFT_W-1:0]      w_shift;
    logic [tsrb_pkg::DELAY_W-1:0]      w_delay_raw;
    logic [31:0]                       w_delay;
    logic [31:0]                       w_age;

    assign w_resync_at = i_item.now_ms + {1'b0, i_cfg.resync_period_ms};

    // Next state and event flags for one item
    always_comb begin
        n_valid_flag      = r_valid_flag;
        n_request_pending = r_request_pending;
        n_next_try_ms     = r_next_try_ms;
        n_next_resync_ms  = r_next_resync_ms;
        n_fail_count      = r_fail_count;
        n_last_sync_ms    = r_last_sync_ms;
        o_res             = '0;
        w_shift           = '0;
        w_delay_raw       = '0;
        w_delay           = '0;

        case (i_item.opcode)
            tsrb_pkg::OP_START: begin
                n_valid_flag         = 1'b0;
                n_request_pending    = 1'b1;
                n_next_try_ms        = '0;
                n_next_resync_ms     = w_resync_at;
                n_fail_count         = '0;
                o_res.restart_client = 1'b1;
            end
            tsrb_pkg::OP_REQUEST: begin
                n_request_pending    = 1'b1;
                n_next_try_ms        = '0;
                o_res.restart_client = 1'b1;
            end
            tsrb_pkg::OP_TICK: begin
                // Periodic resync once time is valid and the period ran out
                if (r_valid_flag && tsrb_pkg::reached(i_item.now_ms, r_next_resync_ms)) begin
                    n_request_pending    = 1'b1;
                    n_next_try_ms        = '0;
                    n_next_resync_ms     = w_resync_at;
                    o_res.restart_client = 1'b1;
                end
                // Check the wall clock once the retry time has come
                if (n_request_pending && tsrb_pkg::reached(i_item.now_ms, n_next_try_ms)) begin
                    if (i_item.wall_seconds >= i_cfg.min_valid_seconds) begin
                        o_res.first_sync  = ~r_valid_flag;
                        o_res.sync_ok     = 1'b1;
                        n_valid_flag      = 1'b1;
                        n_last_sync_ms    = i_item.now_ms;
                        n_request_pending = 1'b0;
                        n_fail_count      = '0;
                        n_next_resync_ms  = w_resync_at;
                    end else begin
                        o_res.sync_failed = 1'b1;
                        if (tsrb_pkg::restart_due(r_fail_count)) begin
                            o_res.restart_client = 1'b1;
                        end
                        if (r_fail_count < tsrb_pkg::MAX_ATTEMPTS) begin
                            n_fail_count = r_fail_count + 4'd1;
                        end
                        // Capped exponential backoff
                        if (n_fail_count > 4'(tsrb_pkg::SHIFT_LIMIT)) begin
                            w_shift = tsrb_pkg::SHIFT_W'(tsrb_pkg::SHIFT_LIMIT);
                        end else begin
                            w_shift = n_fail_count[tsrb_pkg::SHIFT_W-1:0];
                        end
                        w_delay_raw = tsrb_pkg::DELAY_W'(i_cfg.backoff_base_ms) << w_shift;
                        if (32'(w_delay_raw) > i_cfg.backoff_cap_ms) begin
                            w_delay = i_cfg.backoff_cap_ms;
                        end else begin
                            w_delay = 32'(w_delay_raw);
                        end
                        n_next_try_ms = i_item.now_ms + w_delay;
                    end
                end
            end
            default: ;
        endcase

        // Age since the last good sync, after this item
        w_age               = i_item.now_ms - n_last_sync_ms;
        o_res.time_valid    = n_valid_flag;
        o_res.stale         = ~n_valid_flag || (w_age > i_cfg.stale_limit_ms);
        o_res.attempt_count = n_fail_count;
        o_res.retry_at_ms   = n_next_try_ms;
    end

    // Hold state, advance when an item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_flag      <= 1'b0;
            r_request_pending <= 1'b0;
            r_next_try_ms     <= '0;
            r_next_resync_ms  <= '0;
            r_fail_count      <= '0;
            r_last_sync_ms    <= '0;
        end else if (i_en) begin
            r_valid_flag      <= n_valid_flag;
            r_request_pending <= n_request_pending;
            r_next_try_ms     <= n_next_try_ms;
            r_next_resync_ms  <= n_next_resync_ms;
            r_fail_count      <= n_fail_count;
            r_last_sync_ms    <= n_last_sync_ms;
        end
    end

endmodule

[src/time_sync_retry_backoff_top.sv]
// ----------------------------------------------------------------------------
// time_sync_retry_backoff_top: clock-sync attempt scheduler with backoff
//
//   channel  dir  handshake                 payload
//   input    in   i_in_valid / o_in_stall   i_opcode, i_now_ms, i_wall_seconds
//   result   out  o_out_valid / i_out_stall o_restart_client .. o_retry_at_ms
//   config   in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while the result moves on; an item's result is offered from
// the result register (the input register feeds it and the state update).
// Reset (synchronous, i_rst_n low) clears scheduling state and loads register
// defaults. A stalled result holds in the result register while the input
// register still takes one more item; further input stalls until the result
// moves on.
// ----------------------------------------------------------------------------
module time_sync_retry_backoff_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [31:0]                    i_now_ms,
    input  logic [31:0]                    i_wall_seconds,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_restart_client,
    output logic                           o_sync_ok,
    output logic                           o_first_sync,
    output logic                           o_sync_failed,
    output logic                           o_time_valid,
    output logic                           o_stale,
    output logic [3:0]                     o_attempt_count,
    output logic [31:0]                    o_retry_at_ms,
    // config channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tsrb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    tsrb_pkg::t_cfg    w_cfg;
    tsrb_pkg::t_item   r_item;
    tsrb_pkg::t_result w_res;
    tsrb_pkg::t_result r_res;
    logic              r_in_vld;
    logic              r_out_vld;
    logic              w_adv;
    logic              w_in_xfer;
    logic              w_step;

    tsrb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tsrb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_en    (w_step),
        .i_item  (r_item),
        .o_res   (w_res)
    );

    // Pipeline control: result register free or being drained
    assign w_adv      = ~r_out_vld | ~i_out_stall;
    assign o_in_stall = r_in_vld & ~w_adv;
    assign w_in_xfer  = i_in_valid & ~o_in_stall;
    assign w_step     = r_in_vld & w_adv;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Input and result payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_item.opcode       <= i_opcode;
            r_item.now_ms       <= i_now_ms;
            r_item.wall_seconds <= i_wall_seconds;
        end
        if (w_step) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_restart_client = r_res.restart_client;
    assign o_sync_ok        = r_res.sync_ok;
    assign o_first_sync     = r_res.first_sync;
    assign o_sync_failed    = r_res.sync_failed;
    assign o_time_valid     = r_res.time_valid;
    assign o_stale          = r_res.stale;
    assign o_attempt_count  = r_res.attempt_count;
    assign o_retry_at_ms    = r_res.retry_at_ms;

    // A check either succeeds or fails, never both
    a_ok_xor_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_sync_ok && o_sync_failed))
        else $error("sync_ok and sync_failed both set");

    // A first sync is a success that leaves time valid
    a_first_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_first_sync) |-> (o_sync_ok && o_time_valid))
        else $error("first_sync without a valid success");

    // A success clears the attempt count and leaves time fresh
    a_ok_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sync_ok) |-> (o_attempt_count == 4'd0 && !o_stale))
        else $error("success left attempts or stale flag set");

    // The attempt count saturates
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_attempt_count <= tsrb_pkg::MAX_ATTEMPTS))
        else $error("attempt count beyond saturation");

endmodule

[dv/tsrb_retry_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsrb_retry_checker: result checker for the sync retry backoff timer
// Watches the input, result and config channels of the block. Every input
// transfer runs through a local model of the sync scheduler. The predicted
// record is queued and compared with the next result transfer. Reports the
// failure count and the number of results still owed.
// ----------------------------------------------------------------------------
module tsrb_retry_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [31:0]                    i_now_ms,
    input  logic [31:0]                    i_wall_seconds,
    // result channel
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_restart_client,
    input  logic                           i_sync_ok,
    input  logic                           i_first_sync,
    input  logic                           i_sync_failed,
    input  logic                           i_time_valid,
    input  logic                           i_stale,
    input  logic [3:0]                     i_attempt_count,
    input  logic [31:0]                    i_retry_at_ms,
    // config channel
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [tsrb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    // status
    output int                             o_errors,
    output int                             o_pending
);

    localparam int REPORT_MAX = 10;

    // Model copy of the registers and the scheduling state
    tsrb_pkg::t_cfg    sched_cfg;
    logic              time_ok;
    logic              sync_wanted;
    logic [31:0]       retry_ms;
    logic [31:0]       resync_due_ms;
    logic [3:0]        fails;
    logic [31:0]       last_good_ms;

    tsrb_pkg::t_result sched_results_q[$];
    int                err_cnt;

    // True when a lies at or after b on the wrapping millisecond clock
    function automatic logic time_due(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] gap;
        gap = a - b;
        return !gap[31];
    endfunction

    function automatic string show_result(input tsrb_pkg::t_result r);
        return $sformatf("rst=%0b ok=%0b first=%0b fail=%0b valid=%0b stale=%0b att=%0d retry=%h",
                         r.restart_client, r.sync_ok, r.first_sync, r.sync_failed,
                         r.time_valid, r.stale, r.attempt_count, r.retry_at_ms);
    endfunction

    // Advance the scheduler by one item and return the record it reports
    function automatic tsrb_pkg::t_result predict_sched_step(input tsrb_pkg::t_item it);
        tsrb_pkg::t_result r;
        logic [3:0]        sh;
        logic [47:0]       delay;
        logic [31:0]       age;
        r = '0;
        case (it.opcode)
            tsrb_pkg::OP_START: begin
                time_ok       = 1'b0;
                sync_wanted   = 1'b1;
                retry_ms      = '0;
                resync_due_ms = it.now_ms + {1'b0, sched_cfg.resync_period_ms};
                fails         = '0;
                r.restart_client = 1'b1;
            end
            tsrb_pkg::OP_REQUEST: begin
                sync_wanted = 1'b1;
                retry_ms    = '0;
                r.restart_client = 1'b1;
            end
            tsrb_pkg::OP_TICK: begin
                // periodic resync once the period has run out
                if (time_ok && time_due(it.now_ms, resync_due_ms)) begin
                    sync_wanted   = 1'b1;
                    retry_ms      = '0;
                    resync_due_ms = it.now_ms + {1'b0, sched_cfg.resync_period_ms};
                    r.restart_client = 1'b1;
                end
                // check the wall clock once the retry time has come
                if (sync_wanted && time_due(it.now_ms, retry_ms)) begin
                    if (it.wall_seconds >= sched_cfg.min_valid_seconds) begin
                        r.first_sync  = !time_ok;
                        time_ok       = 1'b1;
                        last_good_ms  = it.now_ms;
                        sync_wanted   = 1'b0;
                        fails         = '0;
                        resync_due_ms = it.now_ms + {1'b0, sched_cfg.resync_period_ms};
                        r.sync_ok     = 1'b1;
                    end else begin
                        r.sync_failed = 1'b1;
                        if (fails == 0 || (fails % tsrb_pkg::RESTART_EVERY) == 0) begin
                            r.restart_client = 1'b1;
                        end
                        if (fails < tsrb_pkg::MAX_ATTEMPTS) begin
                            fails = fails + 4'd1;
                        end
                        sh    = (fails > tsrb_pkg::SHIFT_LIMIT) ?
                                4'(tsrb_pkg::SHIFT_LIMIT) : fails;
                        delay = {32'd0, sched_cfg.backoff_base_ms} << sh;
                        if (delay > {16'd0, sched_cfg.backoff_cap_ms}) begin
                            delay = {16'd0, sched_cfg.backoff_cap_ms};
                        end
                        retry_ms = it.now_ms + delay[31:0];
                    end
                end
            end
            default: begin
                // reserved opcode: state untouched, flags stay low
            end
        endcase
        age             = it.now_ms - last_good_ms;
        r.time_valid    = time_ok;
        r.stale         = !time_ok || (age > sched_cfg.stale_limit_ms);
        r.attempt_count = fails;
        r.retry_at_ms   = retry_ms;
        return r;
    endfunction

    // Follow the channels at each edge
    always @(posedge i_clk) begin : watch
        tsrb_pkg::t_item   item;
        tsrb_pkg::t_result got;
        tsrb_pkg::t_result want;
        if (!i_rst_n) begin
            sched_cfg.resync_period_ms  = tsrb_pkg::RESYNC_PERIOD_RST;
            sched_cfg.min_valid_seconds = tsrb_pkg::MIN_VALID_SEC_RST;
            sched_cfg.backoff_base_ms   = tsrb_pkg::BACKOFF_BASE_RST;
            sched_cfg.backoff_cap_ms    = tsrb_pkg::BACKOFF_CAP_RST;
            sched_cfg.stale_limit_ms    = tsrb_pkg::STALE_LIMIT_RST;
            time_ok       = 1'b0;
            sync_wanted   = 1'b0;
            retry_ms      = '0;
            resync_due_ms = '0;
            fails         = '0;
            last_good_ms  = '0;
            sched_results_q.delete();
        end else begin
            // register write
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tsrb_pkg::REG_RESYNC_PERIOD:
                        sched_cfg.resync_period_ms  = i_cfg_data[30:0];
                    tsrb_pkg::REG_MIN_VALID_SEC:
                        sched_cfg.min_valid_seconds = i_cfg_data;
                    tsrb_pkg::REG_BACKOFF_BASE:
                        sched_cfg.backoff_base_ms   = i_cfg_data[15:0];
                    tsrb_pkg::REG_BACKOFF_CAP:
                        sched_cfg.backoff_cap_ms    = i_cfg_data;
                    tsrb_pkg::REG_STALE_LIMIT:
                        sched_cfg.stale_limit_ms    = i_cfg_data;
                    default: ;
                endcase
            end
            // result transfer: compare with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got = {i_restart_client, i_sync_ok, i_first_sync, i_sync_failed,
                       i_time_valid, i_stale, i_attempt_count, i_retry_at_ms};
                if (sched_results_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX) begin
                        $display("[%0t] unexpected result: %s", $realtime, show_result(got));
                    end
                end else begin
                    want = sched_results_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_MAX) begin
                            $display("[%0t] mismatch exp: %s", $realtime, show_result(want));
                            $display("[%0t]          act: %s", $realtime, show_result(got));
                        end
                    end
                end
            end
            // input transfer: predict its result
            if (i_in_valid && !i_in_stall) begin
                item = {i_opcode, i_now_ms, i_wall_seconds};
                sched_results_q.push_back(predict_sched_step(item));
            end
        end
        o_pending <= sched_results_q.size();
        o_errors  <= err_cnt;
    end

endmodule

[dv/tb_time_sync_retry_backoff_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_time_sync_retry_backoff_top: testbench for the sync retry backoff timer
// Runs a directed sequence under the register defaults, then phases of
// random start/request/tick traffic over several register settings with
// sender gaps and receiver stalls. Checking is left to tsrb_retry_checker.
// ----------------------------------------------------------------------------
module tb_time_sync_retry_backoff_top;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_GAP    = 4;
    localparam int PHASE_ITEMS  = 130;

    localparam logic [1:0]                     OP_RESERVED    = 2'd3;
    localparam logic [tsrb_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd5;

    logic                           i_clk;
    logic                           i_rst_n        = 1'b0;
    logic                           i_in_valid     = 1'b0;
    logic                           o_in_stall;
    logic [1:0]                     i_opcode       = '0;
    logic [31:0]                    i_now_ms       = '0;
    logic [31:0]                    i_wall_seconds = '0;
    logic                           o_out_valid;
    logic                           i_out_stall    = 1'b0;
    logic                           o_restart_client;
    logic                           o_sync_ok;
    logic                           o_first_sync;
    logic                           o_sync_failed;
    logic                           o_time_valid;
    logic                           o_stale;
    logic [3:0]                     o_attempt_count;
    logic [31:0]                    o_retry_at_ms;
    logic                           i_cfg_valid    = 1'b0;
    logic                           o_cfg_ready;
    logic [tsrb_pkg::CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [31:0]                    i_cfg_data     = '0;

    int          fail_cnt;
    int          owed_cnt;
    int          gap_pct   = 0;
    int          stall_pct = 0;
    logic        hold_req  = 1'b0;

    // Shadow of the register settings, used to shape the time steps
    logic [31:0] cur_period = {1'b0, tsrb_pkg::RESYNC_PERIOD_RST};
    logic [31:0] cur_min    = tsrb_pkg::MIN_VALID_SEC_RST;
    logic [15:0] cur_base   = tsrb_pkg::BACKOFF_BASE_RST;
    logic [31:0] cur_cap    = tsrb_pkg::BACKOFF_CAP_RST;
    logic [31:0] uptime     = '0;

    time_sync_retry_backoff_top i_dut (.*);

    tsrb_retry_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_now_ms         (i_now_ms),
        .i_wall_seconds   (i_wall_seconds),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_restart_client (o_restart_client),
        .i_sync_ok        (o_sync_ok),
        .i_first_sync     (o_first_sync),
        .i_sync_failed    (o_sync_failed),
        .i_time_valid     (o_time_valid),
        .i_stale          (o_stale),
        .i_attempt_count  (o_attempt_count),
        .i_retry_at_ms    (o_retry_at_ms),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (fail_cnt),
        .o_pending        (owed_cnt)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver stall: random per cycle, or a long hold-off on request
    initial begin : result_stall
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Offer one item, with random gaps ahead of it, and hold until transfer
    task automatic send_item(input logic [1:0] op, input logic [31:0] now,
                             input logic [31:0] wall);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_now_ms       <= now;
        i_wall_seconds <= wall;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every owed result has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (owed_cnt == 0);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tsrb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Load a full register setting while idle, then set the idling mix
    task automatic set_phase(input logic [31:0] period, input logic [31:0] min_sec,
                             input logic [31:0] base, input logic [31:0] cap,
                             input logic [31:0] stale_lim, input int gap, input int stall);
        drain();
        write_reg(tsrb_pkg::REG_RESYNC_PERIOD, period);
        write_reg(tsrb_pkg::REG_MIN_VALID_SEC, min_sec);
        write_reg(tsrb_pkg::REG_BACKOFF_BASE, base);
        write_reg(tsrb_pkg::REG_BACKOFF_CAP, cap);
        write_reg(tsrb_pkg::REG_STALE_LIMIT, stale_lim);
        cur_period = {1'b0, period[30:0]};
        cur_min    = min_sec;
        cur_base   = base[15:0];
        cur_cap    = cap;
        gap_pct    = gap;
        stall_pct  = stall;
    endtask

    // Random traffic: mostly ticks after a start, with some noise
    task automatic random_items(input int n, input bit press);
        longint unsigned max_delay;
        longint unsigned span;
        logic [1:0]      op;
        logic [31:0]     dt;
        logic [31:0]     wall;
        int              sel;
        send_item(tsrb_pkg::OP_START, uptime, $urandom);
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 4) op = tsrb_pkg::OP_START;
            else if (sel < 10) op = tsrb_pkg::OP_REQUEST;
            else if (sel < 12) op = OP_RESERVED;
            else op = tsrb_pkg::OP_TICK;
            // advance uptime on the scale of the backoff or the resync period
            max_delay = longint'(cur_base) << tsrb_pkg::SHIFT_LIMIT;
            if (max_delay > cur_cap) max_delay = cur_cap;
            span = max_delay + max_delay / 4 + 2;
            sel  = $urandom_range(99);
            if (sel < 35) dt = $urandom_range(3);
            else if (sel < 80) dt = $urandom_range(32'(span));
            else if (sel < 95) dt = $urandom_range(cur_period + cur_period / 2 + 1);
            else dt = $urandom;
            uptime = uptime + dt;
            // wall clock: pass, boundary, or fail against the minimum
            sel = $urandom_range(99);
            if (sel < 40) begin
                wall = $urandom;
                if (wall < cur_min) wall = cur_min;
            end else if (sel < 45) wall = cur_min;
            else if (sel < 50) wall = cur_min - 32'd1;
            else if (cur_min == 0) wall = $urandom;
            else wall = $urandom_range(cur_min - 32'd1, 0);
            send_item(op, uptime, wall);
            if (press && k == n / 3) hold_req = 1'b1;
            if (press && k == 2 * n / 3) drain();
        end
    endtask

    // Stimulus and verdict
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sequence under the register defaults
        send_item(tsrb_pkg::OP_TICK, 32'h0, 32'h0);                // nothing requested
        send_item(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        uptime = 32'd100;
        send_item(tsrb_pkg::OP_START, uptime, 32'h0);
        send_item(tsrb_pkg::OP_TICK, uptime, 32'd1699999999);      // first failure
        send_item(tsrb_pkg::OP_TICK, 32'd2099, 32'd1699999999);    // retry time not yet reached
        uptime = 32'd2100;
        for (int k = 0; k < 10; k++) begin                         // climb to saturation
            send_item(tsrb_pkg::OP_TICK, uptime, 32'd1699999999);
            uptime = uptime + 32'd70000;
        end
        send_item(tsrb_pkg::OP_REQUEST, uptime, 32'h0);
        send_item(tsrb_pkg::OP_TICK, uptime, tsrb_pkg::MIN_VALID_SEC_RST); // exactly at the epoch
        uptime = uptime + 32'd3600001;
        send_item(tsrb_pkg::OP_TICK, uptime, 32'hFFFF_FFFF);       // stale, no check
        uptime = uptime - 32'd3600001 + 32'd21600000;
        send_item(tsrb_pkg::OP_TICK, uptime, 32'hFFFF_FFFF);       // periodic resync
        send_item(tsrb_pkg::OP_START, 32'hFFFF_FFF0, 32'h0);
        send_item(tsrb_pkg::OP_TICK, 32'h0000_0005, 32'hFFFF_FFFF); // check across wrap
        send_item(tsrb_pkg::OP_TICK, 32'h8000_0005, 32'h0);        // half-range jump
        send_item(OP_RESERVED, 32'h8000_0005, 32'h0);
        uptime = 32'h8000_0005;

        // Small periods and delays, full rate, with a long result hold-off
        set_phase(32'd200, 32'd1000, 32'd3, 32'd50, 32'd150, 0, 0);
        random_items(PHASE_ITEMS, 1'b1);
        // Zero period, top epoch, largest base and cap, zero stale limit
        set_phase(32'd0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'd0, 61, 0);
        random_items(PHASE_ITEMS, 1'b0);
        // Longest period, epoch zero, smallest base and cap, widest stale limit
        set_phase(32'h7FFF_FFFF, 32'd0, 32'd1, 32'd1, 32'hFFFF_FFFF, 0, 61);
        random_items(PHASE_ITEMS, 1'b0);
        // Unit period, both sides idling, pressure again
        set_phase(32'd1, 32'd12345678, 32'd1000, 32'd60000, 32'd5000, 30, 30);
        random_items(PHASE_ITEMS, 1'b1);
        // Upper bits beyond the register widths, plus an unused index
        set_phase(32'hFFFF_0123, 32'h8000_0000, 32'hABCD_0010, 32'd200, 32'd700, 0, 0);
        write_reg(CFG_IDX_UNUSED, 32'hDEAD_BEEF);
        random_items(PHASE_ITEMS, 1'b0);

        drain();
        repeat (2 * DRAIN_GAP) @(posedge i_clk);
        if (fail_cnt == 0 && owed_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
